// ----- src/pmmae_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and helpers for the packet memory-map access engine.
// No dependencies; the top level imports this package.
package pmmae_pkg;

   // Size of the byte-wide memory map (8 to 48).
   localparam int MAP_BYTES = 32;
   localparam int MAP_AW    = $clog2(MAP_BYTES);

   // Command header layout.
   localparam int HDR_LEN = 16;
   localparam int HDR_AW  = $clog2(HDR_LEN);
   localparam int MAC_LEN = 6;

   // Reply length counter: header plus up to MAP_BYTES-1 read bytes.
   localparam int CNT_W = $clog2(HDR_LEN + MAP_BYTES);

   // Byte position inside a packet; only offsets below 24 matter.
   localparam int POS_W = 5;
   localparam logic [POS_W-1:0] POS_MAGIC     = POS_W'(12);
   localparam logic [POS_W-1:0] POS_CMD       = POS_W'(13);
   localparam logic [POS_W-1:0] POS_HDR_END   = POS_W'(15);
   localparam logic [POS_W-1:0] POS_PARAM_END = POS_W'(23);
   localparam logic [POS_W-1:0] POS_MAX       = '1;

   // Command codes.
   localparam logic [7:0] CMD_RW    = 8'd0;
   localparam logic [7:0] CMD_FLASH = 8'd1;

   // Configuration registers.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC   = 1'd1;
   localparam logic [7:0] TIMEOUT_RESET = 8'd20;
   localparam logic [7:0] MAGIC_RESET   = 8'h69;

   // Item kinds on both channels.
   localparam logic REQ_BYTE   = 1'b0;
   localparam logic REQ_TICK   = 1'b1;
   localparam logic KIND_REPLY = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   localparam int RSP_DATA_W = 16;

   typedef enum logic [3:0] {
      PK_HEADER  = 4'b0001,
      PK_PARAMS  = 4'b0010,
      PK_WRITE   = 4'b0100,
      PK_DISCARD = 4'b1000
   } pkt_state_type;

   typedef enum logic [1:0] {
      EM_IDLE = 2'b01,
      EM_RUN  = 2'b10
   } emit_state_type;

   typedef enum logic [1:0] {
      SRC_HDR = 2'd0,
      SRC_MAP = 2'd1,
      SRC_ONE = 2'd2
   } byte_src_type;

   // Reply order of the header: source MAC, destination MAC, then the rest.
   function automatic logic [HDR_AW-1:0] hdr_order(input logic [HDR_AW-1:0] idx);
      logic [HDR_AW-1:0] res;
      if (idx < HDR_AW'(MAC_LEN)) begin
         res = idx + HDR_AW'(MAC_LEN);
      end else if (idx < HDR_AW'(2 * MAC_LEN)) begin
         res = idx - HDR_AW'(MAC_LEN);
      end else begin
         res = idx;
      end
      return res;
   endfunction

endpackage

// ----- src/pmmae_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the header store and the memory map.
module pmmae_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/packet_memory_map_access_engine_top.sv -----
`timescale 1ns / 1ps
// Top level of the packet memory-map access engine: packet parser, reply sequencer,
// watchdog counter and output register. Depends on pmmae_pkg and pmmae_ram.
//
//  Channel   Dir  Handshake              Payload
//  req_      in   req_tvalid/req_tready  tdata data_byte, tuser cmd, tlast last
//  rsp_      out  rsp_tvalid/rsp_tready  tdata out_byte/commit_flash/timed_out,
//                                        tuser kind, tlast out_last
//  csr_      in   csr_valid/csr_ready    csr_index, csr_wdata
//
// Packet bytes are taken one per cycle while no reply is read out; ticks likewise, but only
// while the output register can take them. A reply is read out of the header and map RAMs at
// one byte per cycle while rsp_ does not stall; req_tready stays low until the last reply byte
// sits in the output register. A stalled rsp_ side holds ticks and the reply sequencer, but
// never packet bytes; a reply that a byte starts waits in the sequencer. Reset is synchronous;
// the map reads as zeros through per-entry valid bits, so there is no clearing pass.
module packet_memory_map_access_engine_top (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [7:0] data_byte
   input  logic                              req_tuser,  // [0] cmd
   input  logic                              req_tlast,
   // Response stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pmmae_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // [7:0] out_byte, [8] commit_flash,
                                                          // [9] timed_out, [15:10] zero
   output logic                              rsp_tuser,  // [0] kind
   output logic                              rsp_tlast,
   // Configuration write port.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pmmae_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [7:0]                        csr_wdata
);

   import pmmae_pkg::*;

   localparam int ADD_W = 17;
   localparam logic [1:0] PW_RADDR = 2'd0;
   localparam logic [1:0] PW_RLEN  = 2'd1;
   localparam logic [1:0] PW_WADDR = 2'd2;
   localparam logic [1:0] PW_WLEN  = 2'd3;

   // Configuration and watchdog.
   logic [7:0] timeout_ff, timeout_in;
   logic [7:0] magic_ff, magic_in;
   logic [7:0] idle_ticks_ff, idle_ticks_in;

   // Packet parser.
   pkt_state_type     pkt_state_ff, pkt_state_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [7:0]        cmd_ff, cmd_in;
   logic [15:0]       ra_ff, ra_in, rl_ff, rl_in, wa_ff, wa_in, wl_ff, wl_in;
   logic [MAP_AW-1:0] wr_addr_ff, wr_addr_in;
   logic [MAP_AW-1:0] wr_left_ff, wr_left_in;
   logic [MAP_BYTES-1:0] map_vld_ff, map_vld_in;

   // Reply sequencer.
   emit_state_type    emit_ff, emit_in;
   logic [CNT_W-1:0]  iss_ff, iss_in;
   logic [CNT_W-1:0]  num_ff, num_in;
   logic              cmt_ff, cmt_in;
   logic [MAP_AW-1:0] rd_addr_ff, rd_addr_in;
   logic              pend_ff, pend_in;
   byte_src_type      pend_src_ff, pend_src_in;
   logic              pend_last_ff, pend_last_in;
   logic              pend_vld_ff, pend_vld_in;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_kind_ff, rsp_kind_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_commit_ff, rsp_commit_in;
   logic       rsp_timed_ff, rsp_timed_in;

   logic req_fire, tick_fire, byte_fire, slot_free, tick_flag, magic_ok;
   logic hdr_we, map_we, hdr_re, map_re;
   logic start, start_cmt;
   logic [CNT_W-1:0]  start_num;
   logic [MAP_AW-1:0] start_rd_addr;
   logic [15:0] wl_next;
   logic rd_ok, wr_ok;
   logic issue, load;
   byte_src_type issue_src;
   logic [HDR_AW-1:0] hdr_raddr;
   logic [7:0] hdr_rdata, map_rdata, load_byte;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   // Packet bytes are never held back by a stalled response side.
   assign req_tready = (emit_ff == EM_IDLE) && (slot_free || (req_tuser == REQ_BYTE));
   assign req_fire   = req_tvalid && req_tready;
   assign tick_fire  = req_fire && (req_tuser == REQ_TICK);
   assign byte_fire  = req_fire && (req_tuser == REQ_BYTE);
   assign tick_flag  = idle_ticks_ff > timeout_ff;
   assign csr_ready  = 1'b1;

   // Configuration writes and watchdog counter.
   always_comb begin
      timeout_in    = timeout_ff;
      magic_in      = magic_ff;
      idle_ticks_in = idle_ticks_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TIMEOUT: timeout_in = csr_wdata;
            CSR_MAGIC:   magic_in   = csr_wdata;
            default:     ;
         endcase
      end
      if (tick_fire) begin
         if (!tick_flag && (idle_ticks_ff != 8'hFF)) begin
            idle_ticks_in = idle_ticks_ff + 8'd1;
         end
      end else if (magic_ok) begin
         idle_ticks_in = '0;
      end
   end

   // Packet parser.
   assign wl_next = {wl_ff[7:0], req_tdata};
   assign rd_ok   = ({1'b0, ra_ff} + {1'b0, rl_ff}) < ADD_W'(MAP_BYTES);
   assign wr_ok   = ({1'b0, wa_ff} + {1'b0, wl_next}) < ADD_W'(MAP_BYTES);

   always_comb begin
      pkt_state_in  = pkt_state_ff;
      pos_in        = pos_ff;
      cmd_in        = cmd_ff;
      ra_in         = ra_ff;
      rl_in         = rl_ff;
      wa_in         = wa_ff;
      wl_in         = wl_ff;
      wr_addr_in    = wr_addr_ff;
      wr_left_in    = wr_left_ff;
      map_vld_in    = map_vld_ff;
      hdr_we        = 1'b0;
      map_we        = 1'b0;
      magic_ok      = 1'b0;
      start         = 1'b0;
      start_cmt     = 1'b0;
      start_num     = CNT_W'(HDR_LEN);
      start_rd_addr = ra_ff[MAP_AW-1:0];
      if (byte_fire) begin
         unique case (pkt_state_ff)
            PK_HEADER: begin
               hdr_we = 1'b1;
               if (pos_ff == POS_MAGIC) begin
                  if (req_tdata != magic_ff) begin
                     pkt_state_in = PK_DISCARD;
                  end else begin
                     magic_ok = 1'b1;
                  end
               end else if (pos_ff == POS_CMD) begin
                  cmd_in = req_tdata;
               end else if (pos_ff == POS_HDR_END) begin
                  if (cmd_ff == CMD_RW) begin
                     pkt_state_in = PK_PARAMS;
                  end else begin
                     start        = 1'b1;
                     start_cmt    = (cmd_ff == CMD_FLASH);
                     start_num    = (cmd_ff == CMD_FLASH) ? CNT_W'(HDR_LEN + 1)
                                                          : CNT_W'(HDR_LEN);
                     pkt_state_in = PK_DISCARD;
                  end
               end
            end
            PK_PARAMS: begin
               // Offsets 16..23 carry four big-endian words, two bytes each.
               case (pos_ff[2:1])
                  PW_RADDR: ra_in = {ra_ff[7:0], req_tdata};
                  PW_RLEN:  rl_in = {rl_ff[7:0], req_tdata};
                  PW_WADDR: wa_in = {wa_ff[7:0], req_tdata};
                  PW_WLEN:  wl_in = wl_next;
                  default:  ;
               endcase
               if (pos_ff == POS_PARAM_END) begin
                  start = 1'b1;
                  if (rd_ok && wr_ok) begin
                     start_num    = CNT_W'(HDR_LEN) + CNT_W'(rl_ff[MAP_AW-1:0]);
                     wr_addr_in   = wa_ff[MAP_AW-1:0];
                     wr_left_in   = wl_next[MAP_AW-1:0];
                     pkt_state_in = PK_WRITE;
                  end else begin
                     pkt_state_in = PK_DISCARD;
                  end
               end
            end
            PK_WRITE: begin
               if (wr_left_ff != '0) begin
                  map_we     = 1'b1;
                  map_vld_in = map_vld_ff | (MAP_BYTES'(1) << wr_addr_ff);
                  wr_addr_in = wr_addr_ff + 1'b1;
                  wr_left_in = wr_left_ff - 1'b1;
               end
            end
            PK_DISCARD: ;
            default: ;
         endcase
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 1'b1;
         end
         if (req_tlast) begin
            pkt_state_in = PK_HEADER;
            pos_in       = '0;
         end
      end
   end

   // Reply sequencer: one read issued per cycle unless rsp_ stalls; data loads on slot_free.
   assign issue = (emit_ff == EM_RUN) && (iss_ff != num_ff) && (!pend_ff || slot_free);
   assign load  = pend_ff && slot_free;

   always_comb begin
      if (iss_ff < CNT_W'(HDR_LEN)) begin
         issue_src = SRC_HDR;
      end else if (cmt_ff) begin
         issue_src = SRC_ONE;
      end else begin
         issue_src = SRC_MAP;
      end
   end

   assign hdr_raddr = hdr_order(iss_ff[HDR_AW-1:0]);
   assign hdr_re    = issue && (issue_src == SRC_HDR);
   assign map_re    = issue && (issue_src == SRC_MAP);

   always_comb begin
      emit_in      = emit_ff;
      iss_in       = iss_ff;
      num_in       = num_ff;
      cmt_in       = cmt_ff;
      rd_addr_in   = rd_addr_ff;
      pend_in      = pend_ff;
      pend_src_in  = pend_src_ff;
      pend_last_in = pend_last_ff;
      pend_vld_in  = pend_vld_ff;
      if (issue) begin
         iss_in       = iss_ff + 1'b1;
         pend_in      = 1'b1;
         pend_src_in  = issue_src;
         pend_last_in = ((iss_ff + 1'b1) == num_ff);
         pend_vld_in  = map_vld_ff[rd_addr_ff];
         if (issue_src == SRC_MAP) begin
            rd_addr_in = rd_addr_ff + 1'b1;
         end
      end else if (load) begin
         pend_in = 1'b0;
      end
      if (load && pend_last_ff) begin
         emit_in = EM_IDLE;
      end
      if (start) begin
         emit_in    = EM_RUN;
         iss_in     = '0;
         num_in     = start_num;
         cmt_in     = start_cmt;
         rd_addr_in = start_rd_addr;
      end
   end

   always_comb begin
      case (pend_src_ff)
         SRC_HDR: load_byte = hdr_rdata;
         SRC_MAP: load_byte = pend_vld_ff ? map_rdata : 8'd0;
         default: load_byte = 8'd1;
      endcase
   end

   // Output register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_commit_in = rsp_commit_ff;
      rsp_timed_in  = rsp_timed_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KIND_REPLY;
         rsp_byte_in   = load_byte;
         rsp_last_in   = pend_last_ff;
         rsp_commit_in = cmt_ff;
         rsp_timed_in  = 1'b0;
      end else if (tick_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KIND_TICK;
         rsp_byte_in   = 8'd0;
         rsp_last_in   = 1'b0;
         rsp_commit_in = 1'b0;
         rsp_timed_in  = tick_flag;
      end else if (rsp_tready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= TIMEOUT_RESET;
         magic_ff      <= MAGIC_RESET;
         idle_ticks_ff <= '0;
         pkt_state_ff  <= PK_HEADER;
         pos_ff        <= '0;
         map_vld_ff    <= '0;
         emit_ff       <= EM_IDLE;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         timeout_ff    <= timeout_in;
         magic_ff      <= magic_in;
         idle_ticks_ff <= idle_ticks_in;
         pkt_state_ff  <= pkt_state_in;
         pos_ff        <= pos_in;
         map_vld_ff    <= map_vld_in;
         emit_ff       <= emit_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      ra_ff         <= ra_in;
      rl_ff         <= rl_in;
      wa_ff         <= wa_in;
      wl_ff         <= wl_in;
      wr_addr_ff    <= wr_addr_in;
      wr_left_ff    <= wr_left_in;
      iss_ff        <= iss_in;
      num_ff        <= num_in;
      cmt_ff        <= cmt_in;
      rd_addr_ff    <= rd_addr_in;
      pend_src_ff   <= pend_src_in;
      pend_last_ff  <= pend_last_in;
      pend_vld_ff   <= pend_vld_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_commit_ff <= rsp_commit_in;
      rsp_timed_ff  <= rsp_timed_in;
   end

   pmmae_ram #(
      .WIDTH(8),
      .DEPTH(HDR_LEN)
   ) u_hdr_ram (
      .clock(clock),
      .we   (hdr_we),
      .waddr(pos_ff[HDR_AW-1:0]),
      .wdata(req_tdata),
      .re   (hdr_re),
      .raddr(hdr_raddr),
      .rdata(hdr_rdata)
   );

   pmmae_ram #(
      .WIDTH(8),
      .DEPTH(MAP_BYTES)
   ) u_map_ram (
      .clock(clock),
      .we   (map_we),
      .waddr(wr_addr_ff),
      .wdata(req_tdata),
      .re   (map_re),
      .raddr(rd_addr_ff),
      .rdata(map_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(RSP_DATA_W - 10)'(0), rsp_timed_ff, rsp_commit_ff, rsp_byte_ff};

   // The request side is closed while a reply is being read out.
   a_no_accept_in_reply: assert property (@(posedge clock) disable iff (reset)
      (emit_ff == EM_RUN) |-> !req_tready)
      else $error("request accepted during reply readout");

   // Loading the final reply byte ends the readout and shows a marked last byte.
   a_last_ends_reply: assert property (@(posedge clock) disable iff (reset)
      (load && pend_last_ff) |=> ((emit_ff == EM_IDLE) && rsp_tvalid && rsp_tlast))
      else $error("reply did not end on its last byte");

   // A read in flight only exists while a reply is running.
   a_pend_in_reply: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (emit_ff == EM_RUN))
      else $error("pending RAM read outside a reply");

   // The issue counter never passes the reply length.
   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (emit_ff == EM_RUN) |-> (iss_ff <= num_ff))
      else $error("reply issue counter overran");

endmodule
